>>> rtl/callsign_hash_table_aging_assert.svh
// Assertion macros for the callsign hash table blocks.
// No dependencies; included by the controller and the datapath.
`ifndef CALLSIGN_HASH_TABLE_AGING_ASSERT_SVH
`define CALLSIGN_HASH_TABLE_AGING_ASSERT_SVH

// same-cycle implication
`define CHTA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHTA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/chta_pkg.sv
// Shared types, constants and helper functions for the callsign hash table.
// No dependencies; used by the interfaces, controller, datapath and top level.
package chta_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int HASH_W            = 22;
   localparam int HEAD_W            = 48;
   localparam int TAIL_W            = 40;
   localparam int NAME_W            = HEAD_W + TAIL_W;
   localparam int NAME_BYTES        = NAME_W / 8;
   localparam int AGE_W             = 8;
   localparam int STATUS_W          = 3;
   localparam int REQ_W             = 2;
   localparam int KIND_W            = 2;
   localparam int COUNT_W           = 9;
   localparam int LOOKUP12_W        = 12;
   localparam int LOOKUP10_W        = 10;
   localparam int SHIFT_12          = HASH_W - LOOKUP12_W;
   localparam int SHIFT_10          = HASH_W - LOOKUP10_W;

   localparam logic [AGE_W-1:0]  MAX_AGE_RESET = AGE_W'(10);
   localparam logic [KIND_W-1:0] KIND_22       = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_12       = KIND_W'(1);

   typedef enum logic [REQ_W-1:0] {
      REQ_SAVE   = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_SWEEP  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_REFRESHED = 3'd0,
      STAT_INSERTED  = 3'd1,
      STAT_DROPPED   = 3'd2,
      STAT_HIT       = 3'd3,
      STAT_MISS      = 3'd4,
      STAT_SWEPT     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_HASHMOD,
      CS_ISSUE,
      CS_PROBE,
      CS_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
      logic [AGE_W-1:0]  age;
      logic [HEAD_W-1:0] head;
      logic [TAIL_W-1:0] tail;
   } slot_type;

   typedef struct packed {
      logic load_req;
      logic finish_short;
      logic issue;
      logic step;
      logic clear_step;
      logic deliver;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic short_req;
      logic is_sweep;
      logic probe_done;
   } dp_stat_type;

   // zero every byte after the first zero byte
   function automatic logic [NAME_W-1:0] clean_name(input logic [HEAD_W-1:0] head,
                                                    input logic [TAIL_W-1:0] tail);
      logic [NAME_W-1:0] name;
      logic              ended;
      name  = {head, tail};
      ended = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (ended) begin
            name[NAME_W-1-8*i -: 8] = 8'h00;
         end else if (name[NAME_W-1-8*i -: 8] == 8'h00) begin
            ended = 1'b1;
         end
      end
      return name;
   endfunction

   function automatic logic hash_hit(input logic [HASH_W-1:0] stored,
                                     input logic [HASH_W-1:0] hash,
                                     input logic [KIND_W-1:0] kind);
      logic hit;
      case (kind)
         KIND_22: hit = (stored == hash);
         KIND_12: hit = (stored[HASH_W-1:SHIFT_12] == hash[LOOKUP12_W-1:0]);
         default: hit = (stored[HASH_W-1:SHIFT_10] == hash[LOOKUP10_W-1:0]);
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/chta_req_if.sv
// Request channel: valid/ready handshake carrying one table request item.
// Depends on chta_pkg for field widths.
interface chta_req_if;
   logic                              valid;
   logic                              ready;
   logic [chta_pkg::REQ_W-1:0]        req_type;
   logic [chta_pkg::HASH_W-1:0]       hash_value;
   logic [chta_pkg::KIND_W-1:0]       hash_kind;
   logic [chta_pkg::HEAD_W-1:0]       name_head;
   logic [chta_pkg::TAIL_W-1:0]       name_tail;

   modport source (output valid, req_type, hash_value, hash_kind, name_head, name_tail,
                   input ready);
   modport sink (input valid, req_type, hash_value, hash_kind, name_head, name_tail,
                 output ready);
endinterface

>>> rtl/chta_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
// Depends on chta_pkg for field widths.
interface chta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [chta_pkg::STATUS_W-1:0] status;
   logic [chta_pkg::HEAD_W-1:0]   found_head;
   logic [chta_pkg::TAIL_W-1:0]   found_tail;
   logic [chta_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, status, found_head, found_tail, entry_count,
                   input ready);
   modport sink (input valid, status, found_head, found_tail, entry_count,
                 output ready);
endinterface

>>> rtl/callsign_hash_table_aging.sv
// Flow: accept, then the HASHMOD and ISSUE start states (HASHMOD also waits for the hash
// remainder of a save or lookup when the table size is not a power of two), one probe cycle
// per slot visited through the single read port, then the output register; a sweep visits all
// TABLE_ENTRIES slots, an empty save or unknown request goes from HASHMOD to DELIVER, a result
// waits in DELIVER while the previous one is not taken; a new item is accepted only after DELIVER.
// Reset: synchronous, active high; a clearing pass invalidates every slot before the first item.
module callsign_hash_table_aging #(
   parameter int TABLE_ENTRIES = chta_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   chta_req_if.sink                      req_chan,
   chta_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_en,
   input  logic [chta_pkg::AGE_W-1:0]    csr_write_data
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   chta_pkg::dp_cmd_type      cmd;
   chta_pkg::dp_stat_type     stat;
   chta_pkg::status_type      out_status;
   logic [CNT_W-1:0]          out_count;

   chta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   chta_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CNT_W         (CNT_W)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_type        (chta_pkg::req_code_type'(req_chan.req_type)),
      .in_hash        (req_chan.hash_value),
      .in_kind        (req_chan.hash_kind),
      .in_head        (req_chan.name_head),
      .in_tail        (req_chan.name_tail),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .out_status     (out_status),
      .out_head       (rsp_chan.found_head),
      .out_tail       (rsp_chan.found_tail),
      .out_count      (out_count)
   );

   assign rsp_chan.status      = out_status;
   assign rsp_chan.entry_count = chta_pkg::COUNT_W'(out_count);

endmodule

>>> rtl/chta_ctrl.sv
// Sequencing state machine for the hash table: clear, accept, probe, deliver.
// Depends on chta_pkg and callsign_hash_table_aging_assert.svh.
`include "callsign_hash_table_aging_assert.svh"

module chta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  chta_pkg::dp_stat_type stat,
   output chta_pkg::dp_cmd_type  cmd
);

   chta_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chta_pkg::CS_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         chta_pkg::CS_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = chta_pkg::CS_IDLE;
            end
         end
         chta_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = chta_pkg::CS_HASHMOD;
            end
         end
         chta_pkg::CS_HASHMOD: begin
            if (stat.short_req) begin
               cmd.finish_short = 1'b1;
               state_in         = chta_pkg::CS_DELIVER;
            end else if (stat.is_sweep || stat.mod_done) begin
               state_in = chta_pkg::CS_ISSUE;
            end
         end
         chta_pkg::CS_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = chta_pkg::CS_PROBE;
         end
         chta_pkg::CS_PROBE: begin
            cmd.step = 1'b1;
            if (stat.probe_done) begin
               state_in = chta_pkg::CS_DELIVER;
            end
         end
         chta_pkg::CS_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.deliver  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = chta_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = chta_pkg::CS_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `CHTA_ASSERT_IMP(a_deliver_free, clock, reset, cmd.deliver, !rsp_valid_ff || rsp_ready, "result overwritten before taken")
   `CHTA_ASSERT_NXT(a_deliver_valid, clock, reset, cmd.deliver, rsp_valid_ff, "delivered result not shown")
   `CHTA_ASSERT_NXT(a_accept_mod, clock, reset, req_valid && req_ready, state_ff == chta_pkg::CS_HASHMOD, "accepted item not started")

endmodule

>>> rtl/chta_dp.sv
// Datapath for the hash table: slot memory, probe address, start index unit,
// aging register, entry count and result registers. Depends on chta_pkg and assert macros.
`include "callsign_hash_table_aging_assert.svh"

module chta_dp #(
   parameter int TABLE_ENTRIES = chta_pkg::TABLE_ENTRIES_DEF,
   parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  chta_pkg::dp_cmd_type               cmd,
   output chta_pkg::dp_stat_type              stat,
   input  chta_pkg::req_code_type             in_type,
   input  logic [chta_pkg::HASH_W-1:0]        in_hash,
   input  logic [chta_pkg::KIND_W-1:0]        in_kind,
   input  logic [chta_pkg::HEAD_W-1:0]        in_head,
   input  logic [chta_pkg::TAIL_W-1:0]        in_tail,
   input  logic                               csr_write_en,
   input  logic [chta_pkg::AGE_W-1:0]         csr_write_data,
   output chta_pkg::status_type               out_status,
   output logic [chta_pkg::HEAD_W-1:0]        out_head,
   output logic [chta_pkg::TAIL_W-1:0]        out_tail,
   output logic [CNT_W-1:0]                   out_count
);

   localparam int                IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0]  LAST  = IDX_W'(TABLE_ENTRIES - 1);

   chta_pkg::slot_type              mem [TABLE_ENTRIES];
   chta_pkg::slot_type              rd_data_ff;
   chta_pkg::slot_type              wr_data;
   logic                            mem_we;
   logic [IDX_W-1:0]                rd_addr;

   logic [chta_pkg::AGE_W-1:0]      max_age_ff;
   chta_pkg::req_code_type          type_ff;
   logic [chta_pkg::HASH_W-1:0]     hash_ff;
   logic [chta_pkg::KIND_W-1:0]     kind_ff;
   logic [chta_pkg::NAME_W-1:0]     name_ff;
   logic [CNT_W-1:0]                occupied_ff;
   logic [IDX_W-1:0]                addr_ff, addr_in, next_addr;
   logic [IDX_W-1:0]                probe_cnt_ff;
   logic [IDX_W-1:0]                start_idx;
   logic                            mod_done;
   chta_pkg::status_type            res_status_ff;
   logic [chta_pkg::NAME_W-1:0]     res_name_ff;
   chta_pkg::status_type            out_status_ff;
   logic [chta_pkg::NAME_W-1:0]     out_name_ff;
   logic [CNT_W-1:0]                out_count_ff;

   logic                            step_we, step_done, occ_inc, occ_dec, name_match;
   chta_pkg::status_type            step_status;
   logic [chta_pkg::NAME_W-1:0]     step_found;

   // start index: hash mod table size
   if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
      assign start_idx = hash_ff[IDX_W-1:0];
      assign mod_done  = 1'b1;
   end else begin : g_recip
      localparam int                       RSHIFT  = chta_pkg::HASH_W + IDX_W;
      localparam int                       RECIP_W = chta_pkg::HASH_W + 2;
      localparam logic [RECIP_W-1:0]       RECIP   =
         RECIP_W'(((64'd1 << RSHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
      localparam logic [IDX_W:0]           ENTRIES = (IDX_W+1)'(TABLE_ENTRIES);
      logic [1:0]                          mstage_ff;
      logic [chta_pkg::HASH_W-1:0]         quo_ff;
      logic [IDX_W-1:0]                    rem_ff;
      logic [chta_pkg::HASH_W+RECIP_W-1:0] prod;
      logic [chta_pkg::HASH_W+IDX_W:0]     back, diff;

      // quotient by reciprocal multiply, then multiply back and subtract
      assign prod      = hash_ff * RECIP;
      assign back      = quo_ff * ENTRIES;
      assign diff      = {{(IDX_W+1){1'b0}}, hash_ff} - back;
      assign mod_done  = (mstage_ff == 2'd2);
      assign start_idx = rem_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            mstage_ff <= '0;
         end else if (cmd.load_req) begin
            mstage_ff <= '0;
         end else if (!mod_done) begin
            mstage_ff <= mstage_ff + 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (mstage_ff == 2'd0) begin
            quo_ff <= chta_pkg::HASH_W'(prod >> RSHIFT);
         end
         if (mstage_ff == 2'd1) begin
            rem_ff <= diff[IDX_W-1:0];
         end
      end
   end

   assign next_addr = (addr_ff == LAST) ? '0 : addr_ff + 1'b1;
   assign rd_addr   = cmd.issue ? (type_ff == chta_pkg::REQ_SWEEP ? '0 : start_idx)
                                : next_addr;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.issue) begin
         addr_in = rd_addr;
      end else if (cmd.step || cmd.clear_step) begin
         addr_in = next_addr;
      end
   end

   // evaluate the slot read in the previous cycle
   assign name_match = (rd_data_ff.hash == hash_ff) &&
                       ({rd_data_ff.head, rd_data_ff.tail} == name_ff);

   always_comb begin
      step_we     = 1'b0;
      step_done   = 1'b0;
      occ_inc     = 1'b0;
      occ_dec     = 1'b0;
      step_status = chta_pkg::STAT_MISS;
      step_found  = '0;
      wr_data     = rd_data_ff;
      case (type_ff)
         chta_pkg::REQ_SAVE: begin
            if (!rd_data_ff.valid) begin
               step_we     = 1'b1;
               step_done   = 1'b1;
               occ_inc     = 1'b1;
               step_status = chta_pkg::STAT_INSERTED;
               wr_data     = '{valid: 1'b1, hash: hash_ff, age: '0,
                               head: name_ff[chta_pkg::NAME_W-1 -: chta_pkg::HEAD_W],
                               tail: name_ff[chta_pkg::TAIL_W-1:0]};
            end else if (name_match) begin
               step_we     = 1'b1;
               step_done   = 1'b1;
               step_status = chta_pkg::STAT_REFRESHED;
               wr_data.age = '0;
            end else if (probe_cnt_ff == LAST) begin
               step_done   = 1'b1;
               step_status = chta_pkg::STAT_DROPPED;
            end
         end
         chta_pkg::REQ_LOOKUP: begin
            if (!rd_data_ff.valid) begin
               step_done = 1'b1;
            end else if (chta_pkg::hash_hit(rd_data_ff.hash, hash_ff, kind_ff)) begin
               step_done   = 1'b1;
               step_status = chta_pkg::STAT_HIT;
               step_found  = {rd_data_ff.head, rd_data_ff.tail};
            end else if (probe_cnt_ff == LAST) begin
               step_done = 1'b1;
            end
         end
         default: begin
            step_status = chta_pkg::STAT_SWEPT;
            step_done   = (probe_cnt_ff == LAST);
            if (rd_data_ff.valid) begin
               step_we = 1'b1;
               if (rd_data_ff.age >= max_age_ff) begin
                  wr_data.valid = 1'b0;
                  occ_dec       = 1'b1;
               end else begin
                  wr_data.age = rd_data_ff.age + 1'b1;
               end
            end
         end
      endcase
      if (cmd.clear_step) begin
         wr_data = '0;
      end
   end

   assign mem_we = (cmd.step && step_we) || cmd.clear_step;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= chta_pkg::MAX_AGE_RESET;
         occupied_ff  <= '0;
         addr_ff      <= '0;
         probe_cnt_ff <= '0;
      end else begin
         if (csr_write_en) begin
            max_age_ff <= csr_write_data;
         end
         if (cmd.step && occ_inc) begin
            occupied_ff <= occupied_ff + 1'b1;
         end else if (cmd.step && occ_dec) begin
            occupied_ff <= occupied_ff - 1'b1;
         end
         addr_ff <= addr_in;
         if (cmd.issue) begin
            probe_cnt_ff <= '0;
         end else if (cmd.step && !step_done) begin
            probe_cnt_ff <= probe_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff <= in_type;
         hash_ff <= in_hash;
         kind_ff <= in_kind;
         name_ff <= chta_pkg::clean_name(in_head, in_tail);
      end
      if (cmd.finish_short) begin
         res_status_ff <= (type_ff == chta_pkg::REQ_NONE) ? chta_pkg::STAT_MISS
                                                          : chta_pkg::STAT_DROPPED;
         res_name_ff   <= '0;
      end else if (cmd.step && step_done) begin
         res_status_ff <= step_status;
         res_name_ff   <= step_found;
      end
      if (cmd.deliver) begin
         out_status_ff <= res_status_ff;
         out_name_ff   <= res_name_ff;
         out_count_ff  <= occupied_ff;
      end
   end

   assign stat.clear_done = (addr_ff == LAST);
   assign stat.mod_done   = mod_done;
   assign stat.short_req  = (type_ff == chta_pkg::REQ_NONE) ||
                            ((type_ff == chta_pkg::REQ_SAVE) &&
                             (name_ff[chta_pkg::NAME_W-1 -: 8] == 8'h00));
   assign stat.is_sweep   = (type_ff == chta_pkg::REQ_SWEEP);
   assign stat.probe_done = step_done;

   assign out_status = out_status_ff;
   assign out_head   = out_name_ff[chta_pkg::NAME_W-1 -: chta_pkg::HEAD_W];
   assign out_tail   = out_name_ff[chta_pkg::TAIL_W-1:0];
   assign out_count  = out_count_ff;

   `CHTA_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occupied_ff <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
   `CHTA_ASSERT_NXT(a_occ_inc, clock, reset, cmd.step && occ_inc, occupied_ff == $past(occupied_ff) + 1'b1, "insert did not count")
   `CHTA_ASSERT_IMP(a_clear_alone, clock, reset, cmd.clear_step, !cmd.step && !cmd.issue && !cmd.load_req, "clear pass overlaps a request")

endmodule
